// File: sv/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg
// Shared widths, register codes and helpers for the running mean square block.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WINDOW  = 256;
  localparam int DEPTH       = MAX_WINDOW - 1;
  localparam int POS_BITS    = $clog2(DEPTH);
  localparam int WLEN_BITS   = $clog2(MAX_WINDOW) + 1;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS - 1;
  localparam int SUM_BITS    = SQ_BITS + POS_BITS;
  localparam int TOTAL_BITS  = SUM_BITS + 1;
  localparam int OUT_BITS    = SQ_BITS;
  localparam int DIV_STEPS   = TOTAL_BITS;
  localparam int CNT_BITS    = $clog2(DIV_STEPS + 1);
  localparam int ADDR_BITS   = 3;
  localparam int IDX_BITS    = ADDR_BITS - 2;
  localparam int DATA_BITS   = 32;

  localparam logic [IDX_BITS-1:0]  REG_WINDOW_LEN = IDX_BITS'(0);
  localparam logic [WLEN_BITS-1:0] WLEN_RESET     = WLEN_BITS'(16);
  localparam logic [WLEN_BITS-1:0] WLEN_MIN       = WLEN_BITS'(2);
  localparam logic [WLEN_BITS-1:0] WLEN_MAX       = WLEN_BITS'(MAX_WINDOW);
  localparam logic [SQ_BITS-1:0]   SQ_MAX         = SQ_BITS'(1) << (SQ_BITS - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_OUTQ   = 5'b10000
  } state_t;

  function automatic logic [SQ_BITS-1:0] square_of(input logic signed [SAMPLE_BITS-1:0] s);
    logic signed [2*SAMPLE_BITS-1:0] p;
    p = s * s;
    return p[SQ_BITS-1:0];
  endfunction

endpackage

// File: sv/rms_if.sv
// ----------------------------------------------------------------------------
// rms_if
// Valid/ready stream channels for samples and mean square results.
// ----------------------------------------------------------------------------
interface rms_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [rms_pkg::SAMPLE_BITS-1:0]     sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rms_out_if;
  logic                                       valid;
  logic                                       ready;
  logic        [rms_pkg::OUT_BITS-1:0]        mean_square;

  modport source (output valid, output mean_square, input ready);
  modport sink   (input valid, input mean_square, output ready);
endinterface

// File: sv/rms_ram.sv
// ----------------------------------------------------------------------------
// rms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 255
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/rms_div.sv
// ----------------------------------------------------------------------------
// rms_div
// Restoring divider, one quotient bit per cycle, window length divisor.
// ----------------------------------------------------------------------------
module rms_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [rms_pkg::TOTAL_BITS-1:0]     dividend,
  input  logic [rms_pkg::WLEN_BITS-1:0]      divisor,
  output logic                               done,
  output logic [rms_pkg::OUT_BITS-1:0]       quotient
);

  logic [rms_pkg::TOTAL_BITS-1:0] quo;
  logic [rms_pkg::WLEN_BITS-1:0]  rem;
  logic [rms_pkg::CNT_BITS-1:0]   cnt;
  logic [rms_pkg::WLEN_BITS:0]    trial;
  logic [rms_pkg::WLEN_BITS:0]    diff;
  logic                           ge;
  logic [rms_pkg::WLEN_BITS-1:0]  rem_next;

  always_comb begin
    trial    = {rem, quo[rms_pkg::TOTAL_BITS-1]};
    ge       = trial >= {1'b0, divisor};
    diff     = trial - {1'b0, divisor};
    rem_next = ge ? diff[rms_pkg::WLEN_BITS-1:0] : trial[rms_pkg::WLEN_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= rms_pkg::CNT_BITS'(rms_pkg::DIV_STEPS);
      end else if (cnt != '0) begin
        cnt  <= cnt - rms_pkg::CNT_BITS'(1);
        done <= (cnt == rms_pkg::CNT_BITS'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (cnt != '0) begin
      quo <= {quo[rms_pkg::TOTAL_BITS-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient = quo[rms_pkg::OUT_BITS-1:0];

endmodule

// File: sv/running_mean_square_top.sv
// ----------------------------------------------------------------------------
// running_mean_square_top
// Mean of squares over a sliding window of signed Q1.15 samples.
//
// Requests arrive on the samples channel, one signed sample each; every
// request yields one unsigned Q1.30 mean square on the results channel. The
// last window_len-1 samples live in a 255-entry RAM, read at the write
// position and written back in the next cycle; the running sum of squares sits
// in a register. The quotient comes from a 40-step bit-serial divider. A
// request passes through the read, update, divide and output states before its
// result reaches the output register; no new request is taken until the
// block is back in idle. When the receiver stalls, the finished result holds
// in the output register while the next request is worked; that one then waits
// in the divider until the register frees. Reset, and any write of window_len
// over the APB port, zero the sum and the write position and mark the RAM
// empty, so the first pass averages against zero samples. window_len reads
// back at address 0; a write keeps the low 9 bits, clamped at 2 and 256.
// ----------------------------------------------------------------------------
module running_mean_square_top (
  input  logic                              clk,
  input  logic                              rst,
  rms_in_if.sink                            samples,
  rms_out_if.source                         results,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rms_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [rms_pkg::DATA_BITS-1:0]     pwdata,
  output logic [rms_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready
);

  rms_pkg::state_t                   state, state_next;
  logic [rms_pkg::WLEN_BITS-1:0]     window_len;
  logic [rms_pkg::WLEN_BITS-1:0]     wlen_new;
  logic [rms_pkg::WLEN_BITS-1:0]     depth_w;
  logic [rms_pkg::POS_BITS-1:0]      depth;
  logic [rms_pkg::POS_BITS-1:0]      write_pos;
  logic [rms_pkg::POS_BITS:0]        pos_inc;
  logic                              pos_wrap;
  logic                              wrapped;
  logic [rms_pkg::SUM_BITS-1:0]      square_sum;
  logic signed [rms_pkg::SAMPLE_BITS-1:0] cur_sample;
  logic signed [rms_pkg::SAMPLE_BITS-1:0] old_sample;
  logic [rms_pkg::SQ_BITS-1:0]       sq_cur;
  logic [rms_pkg::SQ_BITS-1:0]       sq_old;
  logic [rms_pkg::TOTAL_BITS-1:0]    dividend;
  logic                              out_valid;
  logic [rms_pkg::OUT_BITS-1:0]      out_data;
  logic                              out_free;
  logic                              in_fire;
  logic                              cfg_write;
  logic                              cfg_hit;
  logic [rms_pkg::IDX_BITS-1:0]      reg_index;
  logic [rms_pkg::SAMPLE_BITS-1:0]   ram_rdata;
  logic                              ram_we;
  logic                              div_start;
  logic                              div_done;
  logic [rms_pkg::OUT_BITS-1:0]      quotient;

  assign samples.ready = (state == rms_pkg::ST_IDLE);
  assign in_fire       = samples.valid && samples.ready;
  assign results.valid       = out_valid;
  assign results.mean_square = out_data;
  assign out_free      = !out_valid || results.ready;

  assign pready    = 1'b1;
  assign reg_index = paddr[rms_pkg::ADDR_BITS-1:2];
  assign cfg_write = psel && penable && pwrite;
  assign cfg_hit   = cfg_write && (reg_index == rms_pkg::REG_WINDOW_LEN);

  always_comb begin
    wlen_new = pwdata[rms_pkg::WLEN_BITS-1:0];
    if (wlen_new < rms_pkg::WLEN_MIN) begin
      wlen_new = rms_pkg::WLEN_MIN;
    end else if (wlen_new > rms_pkg::WLEN_MAX) begin
      wlen_new = rms_pkg::WLEN_MAX;
    end
  end

  always_comb begin
    if (reg_index == rms_pkg::REG_WINDOW_LEN) begin
      prdata = rms_pkg::DATA_BITS'(window_len);
    end else begin
      prdata = '0;
    end
  end

  assign depth_w  = window_len - rms_pkg::WLEN_BITS'(1);
  assign depth    = depth_w[rms_pkg::POS_BITS-1:0];
  assign pos_inc  = {1'b0, write_pos} + (rms_pkg::POS_BITS+1)'(1);
  assign pos_wrap = pos_inc >= {1'b0, depth};

  assign ram_we     = (state == rms_pkg::ST_READ);
  assign old_sample = wrapped ? $signed(ram_rdata) : '0;

  assign div_start = (state == rms_pkg::ST_UPDATE);

  always_comb begin
    state_next = state;
    unique case (state)
      rms_pkg::ST_IDLE:   if (in_fire) state_next = rms_pkg::ST_READ;
      rms_pkg::ST_READ:   state_next = rms_pkg::ST_UPDATE;
      rms_pkg::ST_UPDATE: state_next = rms_pkg::ST_DIV;
      rms_pkg::ST_DIV:    if (div_done) state_next = rms_pkg::ST_OUTQ;
      rms_pkg::ST_OUTQ:   if (out_free) state_next = rms_pkg::ST_IDLE;
      default:            state_next = rms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rms_pkg::ST_IDLE;
      window_len <= rms_pkg::WLEN_RESET;
      write_pos  <= '0;
      wrapped    <= 1'b0;
      square_sum <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_hit) begin
        window_len <= wlen_new;
        write_pos  <= '0;
        wrapped    <= 1'b0;
        square_sum <= '0;
      end else if (state == rms_pkg::ST_READ) begin
        if (pos_wrap) begin
          write_pos <= '0;
          wrapped   <= 1'b1;
        end else begin
          write_pos <= pos_inc[rms_pkg::POS_BITS-1:0];
        end
      end else if (state == rms_pkg::ST_UPDATE) begin
        square_sum <= square_sum - rms_pkg::SUM_BITS'(sq_old) + rms_pkg::SUM_BITS'(sq_cur);
      end
      if (state == rms_pkg::ST_OUTQ && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_sample <= samples.sample;
      sq_cur     <= rms_pkg::square_of(samples.sample);
    end
    if (state == rms_pkg::ST_READ) begin
      sq_old   <= rms_pkg::square_of(old_sample);
      dividend <= rms_pkg::TOTAL_BITS'(square_sum) + rms_pkg::TOTAL_BITS'(sq_cur);
    end
    if (state == rms_pkg::ST_OUTQ && out_free) begin
      out_data <= quotient;
    end
  end

  rms_ram #(
    .WIDTH (rms_pkg::SAMPLE_BITS),
    .DEPTH (rms_pkg::DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pos),
    .wdata (cur_sample),
    .re    (in_fire),
    .raddr (write_pos),
    .rdata (ram_rdata)
  );

  rms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (window_len),
    .done     (div_done),
    .quotient (quotient)
  );

`ifndef NO_ASSERTIONS
  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    write_pos < depth)
    else $error("write position outside window");

  a_wlen_range: assert property (@(posedge clk) disable iff (rst)
    window_len >= rms_pkg::WLEN_MIN && window_len <= rms_pkg::WLEN_MAX)
    else $error("window length out of range");

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> $past(in_fire))
    else $error("history write without a preceding read");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == rms_pkg::ST_DIV)
    else $error("divider finished outside divide state");

  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data <= rms_pkg::SQ_MAX)
    else $error("mean square above full scale");
`endif

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for running_mean_square_top. Signed samples go in over
// the request channel with random gaps. The receiver stalls at random. Each
// mean square that comes back is checked in order against a sliding-window
// predictor kept in step with every window_len write made over APB. Each write
// is read back, and the run covers the clamp limits, an ignored address and
// full-scale samples.
// ----------------------------------------------------------------------------
module testbench;
  import rms_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HIST_BITS    = 38;

  localparam logic [IDX_BITS-1:0]  REG_UNUSED      = IDX_BITS'(1);
  localparam logic [ADDR_BITS-1:0] ADDR_WINDOW_LEN = {REG_WINDOW_LEN, 2'b00};
  localparam logic [ADDR_BITS-1:0] ADDR_UNUSED     = {REG_UNUSED, 2'b00};

  localparam logic [SAMPLE_BITS-1:0] S_ZERO    = 16'h0000;
  localparam logic [SAMPLE_BITS-1:0] S_MAX_POS = 16'h7fff;
  localparam logic [SAMPLE_BITS-1:0] S_MAX_NEG = 16'h8000;
  localparam logic [SAMPLE_BITS-1:0] S_MINUS_1 = 16'hffff;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_BITS-1:0]  paddr;
  logic [DATA_BITS-1:0]  pwdata;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;

  rms_in_if  samples_if ();
  rms_out_if results_if ();

  running_mean_square_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [SAMPLE_BITS-1:0] past_samples [DEPTH];
  logic [HIST_BITS-1:0]   square_sum;
  int unsigned            write_pos;
  int unsigned            window_len;

  logic [OUT_BITS-1:0]    pending_ms [$];
  logic [OUT_BITS-1:0]    expected_ms;

  bit                     quiet;
  int unsigned            rx_stall;
  int unsigned            cycle_count;
  int unsigned            mismatches;
  int unsigned            samples_sent;
  int unsigned            results_checked;
  int unsigned            windows_tried;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [HIST_BITS-1:0] square_mag(input logic [SAMPLE_BITS-1:0] raw);
    logic [SAMPLE_BITS:0] mag;
    mag = raw[SAMPLE_BITS-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    return HIST_BITS'(mag) * HIST_BITS'(mag);
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < DEPTH; i++) past_samples[i] = '0;
    square_sum = '0;
    write_pos  = 0;
  endfunction

  function automatic logic [OUT_BITS-1:0] step_window(input logic [SAMPLE_BITS-1:0] s);
    logic [HIST_BITS-1:0] sq;
    logic [HIST_BITS:0]   total;
    logic [HIST_BITS:0]   quotient;
    int unsigned          depth;
    depth = window_len - 1;
    if (write_pos >= depth) write_pos = 0;
    sq       = square_mag(s);
    total    = {1'b0, square_sum} + {1'b0, sq};
    quotient = total / (HIST_BITS + 1)'(window_len);
    square_sum = square_sum - square_mag(past_samples[write_pos]) + sq;
    past_samples[write_pos] = s;
    write_pos++;
    if (write_pos >= depth) write_pos = 0;
    return quotient[OUT_BITS-1:0];
  endfunction

  task automatic report(input string what, input logic [63:0] exp, input logic [63:0] act);
    mismatches++;
    if (mismatches <= 10)
      $display("ERROR %s: expected %0d, got %0d (cycle %0d)", what, exp, act, cycle_count);
  endtask

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_ms.size() == 0) begin
        report("mean_square with no request pending", 0, results_if.mean_square);
      end else begin
        expected_ms = pending_ms.pop_front();
        results_checked++;
        if (results_if.mean_square !== expected_ms)
          report("mean_square", expected_ms, results_if.mean_square);
      end
    end
  end

  initial begin
    results_if.ready = 1'b0;
    forever begin
      rx_stall = quiet ? 0 : $urandom_range(0, 16);
      if (rx_stall != 0) begin
        results_if.ready <= 1'b0;
        repeat (rx_stall) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (!results_if.valid);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count, pending_ms.size());
    $display("running_mean_square_top test failed");
    $finish;
  end

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid  <= 1'b1;
    samples_if.sample <= s;
    do @(posedge clk); while (!samples_if.ready);
    pending_ms.push_back(step_window(s));
    samples_sent++;
  endtask

  task automatic wait_idle();
    samples_if.valid <= 1'b0;
    while (pending_ms.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [ADDR_BITS-1:0] addr,
                            input logic [DATA_BITS-1:0] data,
                            output logic [DATA_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_window_len();
    logic [DATA_BITS-1:0] rd;
    apb_access(1'b0, ADDR_WINDOW_LEN, '0, rd);
    if (rd !== DATA_BITS'(window_len)) report("window_len readback", window_len, rd);
  endtask

  task automatic set_window(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
    logic [DATA_BITS-1:0] rd;
    int unsigned          v;
    wait_idle();
    apb_access(1'b1, addr, data, rd);
    if (addr[ADDR_BITS-1:2] == REG_WINDOW_LEN) begin
      v = data[8:0];
      if (v < WLEN_MIN) v = WLEN_MIN;
      if (v > WLEN_MAX) v = WLEN_MAX;
      window_len = v;
      clear_window();
      windows_tried++;
    end
    check_window_len();
  endtask

  task automatic test_first_pass();
    logic [SAMPLE_BITS-1:0] seq [10];
    seq = '{S_ZERO, S_MAX_POS, S_MAX_NEG, S_MINUS_1, 16'h0001,
            16'h4000, 16'hc000, 16'h5555, 16'haaaa, S_ZERO};
    check_window_len();
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  task automatic test_window_clamp();
    set_window(ADDR_WINDOW_LEN, 32'd0);
    repeat (4) send_sample(S_MAX_NEG);
    set_window(ADDR_WINDOW_LEN, 32'd1);
    send_sample(S_MAX_POS);
    send_sample(S_MAX_NEG);
    set_window(ADDR_WINDOW_LEN, 32'd257);
    send_sample(S_MAX_NEG);
    set_window(ADDR_WINDOW_LEN, 32'd511);
    send_sample(S_MAX_POS);
    set_window(ADDR_WINDOW_LEN, 32'h0000_0203);
    send_sample(S_MINUS_1);
    send_sample(S_MAX_NEG);
    // window and history must survive a write to an unmapped address
    set_window(ADDR_UNUSED, 32'd5);
    send_sample(S_MAX_POS);
    send_sample(S_ZERO);
  endtask

  task automatic run_window(input logic [DATA_BITS-1:0] data, input int unsigned count,
                            input bit no_idle);
    logic [SAMPLE_BITS-1:0] corner [4];
    logic [SAMPLE_BITS-1:0] s;
    corner = '{S_ZERO, S_MAX_POS, S_MAX_NEG, S_MINUS_1};
    set_window(ADDR_WINDOW_LEN, data);
    quiet = no_idle;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0) s = corner[$urandom_range(0, 3)];
      else s = SAMPLE_BITS'($urandom);
      send_sample(s);
      if (i == count / 2) wait_idle();
    end
    quiet = 1'b0;
  endtask

  task automatic test_random_windows();
    run_window(32'd2, 150, 1'b0);
    run_window(32'd3, 150, 1'b0);
    run_window(32'd16, 150, 1'b1);
    run_window(32'd255, 320, 1'b0);
    run_window(32'd256, 320, 1'b0);
    repeat (3) run_window(DATA_BITS'($urandom_range(2, 256)), 150, 1'b0);
    run_window($urandom, 150, 1'b0);
  endtask

  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    samples_if.valid  = 1'b0;
    samples_if.sample = '0;
    quiet             = 1'b0;
    mismatches        = 0;
    samples_sent      = 0;
    results_checked   = 0;
    windows_tried     = 0;
    clear_window();
    window_len = WLEN_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_pass();
    test_window_clamp();
    test_random_windows();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d samples sent, %0d mean squares checked, %0d window settings written",
             samples_sent, results_checked, windows_tried);
    $display("covered lengths 2 to 256, clamped writes, an unmapped write, full-scale input");
    if (mismatches == 0 && pending_ms.size() == 0) begin
      $display("running_mean_square_top test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_ms.size());
      $display("running_mean_square_top test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/rms_pkg.sv
sv/rms_if.sv
sv/rms_ram.sv
sv/rms_div.sv
sv/running_mean_square_top.sv
verif/testbench.sv
